### design/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared constants, codes, command and status types for the bounded deque.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Storage geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;

  // Fixed field widths on the stream ports
  localparam int OP_W       = 3;
  localparam int WORD_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic decode;
    logic pop_load;
    logic walk;
    logic finish;
    logic load_out;
  } dq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pop_go;
    logic remove_go;
    logic walk_last;
    logic out_free;
  } dq_stat_t;

  // Ring slot at an offset from a base index, wrapping at DEPTH
  function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

### design/bounded_deque_with_match_removal.sv
// Sequence: an item is captured and decoded; a pop then reads the RAM, a remove walks
//   the held entries, one held entry walked per cycle; the result then goes to the output register.
// A new item is taken only after the last result is in the output register, and not
//   while a finished result waits for m_axis_tready.
// Reset: rst (synchronous) empties the queue; no RAM clearing pass is needed.
// ----------------------------------------------------------------------------
// bounded_deque_with_match_removal
// Bounded double-ended queue in a ring RAM with push/pop at both ends and
// removal of every entry equal to a key, keeping the order of the rest.
// ----------------------------------------------------------------------------
module bounded_deque_with_match_removal
  import dq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // op[2:0], data_word[34:3], zero pad
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // result_word[31:0], status[33:32],
                                                // entry_count[38:34], is_empty[39]
);

  dq_cmd_t  cmd;
  dq_stat_t stat;

  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dq_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

### design/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Controller state machine: sequences decode, pop read, removal walk and
// result hand-off for one operation at a time.
// ----------------------------------------------------------------------------
module dq_ctrl
  import dq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dq_stat_t stat,
  output dq_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_POP    = 6'b000100,
    S_WALK   = 6'b001000,
    S_FIN    = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (stat.remove_go) begin
          state_next = S_WALK;
        end else if (stat.pop_go) begin
          state_next = S_POP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_POP: begin
        cmd.pop_load = 1'b1;
        state_next   = S_DONE;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### design/dq_dpath.sv
// ----------------------------------------------------------------------------
// dq_dpath
// Datapath: ring pointers, ring RAM, removal walk with compaction and the
// output register.
// ----------------------------------------------------------------------------
module dq_dpath
  import dq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  dq_cmd_t                cmd,
  output dq_stat_t               stat,
  input  logic [IN_TDATA_W-1:0]  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data
);

  logic [OP_W-1:0]       op_r;
  logic [DATA_WIDTH-1:0] word_r;
  logic [IDX_W-1:0]      head;
  logic [CNT_W-1:0]      occ;
  logic [CNT_W-1:0]      rd_idx;
  logic [CNT_W-1:0]      kept;
  logic                  found;
  logic [DATA_WIDTH-1:0] result;
  logic [STATUS_W-1:0]   status;

  logic                  is_full;
  logic                  is_emp;
  logic                  is_match;
  logic                  walk_last;
  logic [IDX_W-1:0]      head_dec;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;

  assign is_full   = (occ == CNT_W'(DEPTH));
  assign is_emp    = (occ == '0);
  assign is_match  = (rd_data == word_r);
  assign walk_last = (rd_idx == occ);
  assign head_dec  = (head == '0) ? IDX_W'(DEPTH - 1) : head - 1'b1;

  // Status to the controller
  always_comb begin
    stat.pop_go    = ((op_r == OP_POP_FRONT) || (op_r == OP_POP_BACK)) && !is_emp;
    stat.remove_go = (op_r == OP_REMOVE) && !is_emp;
    stat.walk_last = walk_last;
    stat.out_free  = !out_valid || out_ready;
  end

  // RAM access
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = word_r;
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.decode) begin
      unique case (op_r)
        OP_PUSH_FRONT: begin
          wr_en   = !is_full;
          wr_addr = head_dec;
        end
        OP_PUSH_BACK: begin
          wr_en   = !is_full;
          wr_addr = slot_add(head, occ);
        end
        OP_POP_FRONT: begin
          rd_en   = !is_emp;
          rd_addr = head;
        end
        OP_POP_BACK: begin
          rd_en   = !is_emp;
          rd_addr = slot_add(head, occ - 1'b1);
        end
        OP_REMOVE: begin
          rd_en   = !is_emp;
          rd_addr = head;
        end
        default: begin
          rd_en = 1'b0;
        end
      endcase
    end else if (cmd.walk) begin
      // Move a kept entry down to its compacted slot, fetch the next one
      wr_en   = !is_match;
      wr_addr = slot_add(head, kept);
      wr_data = rd_data;
      rd_en   = !walk_last;
      rd_addr = slot_add(head, rd_idx);
    end
  end

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      occ  <= '0;
    end else if (cmd.decode) begin
      unique case (op_r)
        OP_PUSH_FRONT: begin
          if (!is_full) begin
            head <= head_dec;
            occ  <= occ + 1'b1;
          end
        end
        OP_PUSH_BACK: begin
          if (!is_full) begin
            occ <= occ + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (!is_emp) begin
            head <= slot_add(head, CNT_W'(1));
            occ  <= occ - 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (!is_emp) begin
            occ <= occ - 1'b1;
          end
        end
        default: begin
          occ <= occ;
        end
      endcase
    end else if (cmd.finish) begin
      occ <= kept;
    end
  end

  // Operation payload, walk counters and result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_data[OP_W-1:0];
      word_r <= DATA_WIDTH'(in_data[OP_W +: WORD_W]);
    end
    if (cmd.decode) begin
      result <= '0;
      rd_idx <= CNT_W'(1);
      kept   <= '0;
      found  <= 1'b0;
      unique case (op_r)
        OP_PUSH_FRONT, OP_PUSH_BACK: status <= is_full ? ST_FULL : ST_OK;
        OP_POP_FRONT, OP_POP_BACK, OP_REMOVE: status <= is_emp ? ST_EMPTY : ST_OK;
        default: status <= ST_OK;
      endcase
    end else if (cmd.pop_load) begin
      result <= rd_data;
    end else if (cmd.walk) begin
      if (is_match) begin
        found  <= 1'b1;
        result <= rd_data;
      end else begin
        kept <= kept + 1'b1;
      end
      if (!walk_last) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end else if (cmd.finish) begin
      status <= found ? ST_OK : ST_NOMATCH;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {(occ == '0), COUNT_W'(occ), status, WORD_W'(result)};
    end
  end

endmodule

### design/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks on result consistency and handshake, bound to the top.
// ----------------------------------------------------------------------------
module dq_checker
  import dq_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Drop ready after a transfer while the operation runs
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again before operation finished");

  // Empty flag follows the count, count never exceeds the depth
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[39] == (m_axis_tdata[38:34] == '0))
                      && (m_axis_tdata[38:34] <= COUNT_W'(DEPTH)))
    else $error("inconsistent count or empty flag");

  // Full status only with a full store
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[33:32] == ST_FULL)
      |-> (m_axis_tdata[38:34] == COUNT_W'(DEPTH)) && (m_axis_tdata[31:0] == '0))
    else $error("full status with room left");

  // Empty status only with an empty store
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[33:32] == ST_EMPTY)
      |-> m_axis_tdata[39] && (m_axis_tdata[31:0] == '0))
    else $error("empty status with entries held");

endmodule

bind bounded_deque_with_match_removal dq_checker u_dq_checker (.*);

### tb/sv/bounded_deque_with_match_removal_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_deque_with_match_removal_test
// Drives push, pop, remove and spare operations into the deque stream port
// and checks every result against an in-bench model of the ring store.
// It covers the empty, full, no-match and spare-code cases, random traffic
// with a small key pool so that removals hit, and random stalls on both sides.
// ----------------------------------------------------------------------------
module bounded_deque_with_match_removal_test;
  import dq_pkg::*;

  // Spare operation codes, ignored by the block
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int          DRAIN_WAIT  = 40;
  localparam int          HOLD_CYCLES = 250;

  // Fields of one result transfer
  typedef struct packed {
    logic [WORD_W-1:0]   word;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                empty_flag;
  } deque_result_t;

  // --------------------------------------------------------------------------
  // Deque model and queue of expected results
  // --------------------------------------------------------------------------
  class deque_scoreboard;
    logic [WORD_W-1:0] ring[DEPTH];
    int unsigned       front;
    int unsigned       held;
    deque_result_t     expected_q[$];
    int unsigned       errors;

    function new();
      front  = 0;
      held   = 0;
      errors = 0;
    endfunction

    // Apply one accepted operation to the model and queue its result
    function void note_request(logic [OP_W-1:0] op, logic [WORD_W-1:0] word);
      deque_result_t r;
      int unsigned   kept;
      int unsigned   pos;
      logic          found;
      r.word   = '0;
      r.status = ST_OK;
      case (op)
        OP_PUSH_FRONT: begin
          if (held >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            front       = (front == 0) ? DEPTH - 1 : front - 1;
            ring[front] = word;
            held++;
          end
        end
        OP_PUSH_BACK: begin
          if (held >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            ring[(front + held) % DEPTH] = word;
            held++;
          end
        end
        OP_POP_FRONT: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.word = ring[front];
            front  = (front + 1) % DEPTH;
            held--;
          end
        end
        OP_POP_BACK: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.word = ring[(front + held - 1) % DEPTH];
            held--;
          end
        end
        OP_REMOVE: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            // compact the survivors toward the front
            kept  = 0;
            found = 1'b0;
            for (int unsigned i = 0; i < held; i++) begin
              pos = (front + i) % DEPTH;
              if (ring[pos] == word) begin
                r.word = ring[pos];
                found  = 1'b1;
              end else begin
                ring[(front + kept) % DEPTH] = ring[pos];
                kept++;
              end
            end
            held = kept;
            if (!found) begin
              r.status = ST_NOMATCH;
              r.word   = '0;
            end
          end
        end
        default: begin
        end
      endcase
      r.count      = COUNT_W'(held);
      r.empty_flag = (held == 0);
      expected_q.push_back(r);
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_response(logic [OUT_TDATA_W-1:0] tdata);
      deque_result_t got;
      deque_result_t exp_r;
      got.word       = tdata[31:0];
      got.status     = tdata[33:32];
      got.count      = tdata[38:34];
      got.empty_flag = tdata[39];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, tdata);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.word !== exp_r.word) begin
        $display("%0t: result_word expected %h actual %h", $time, exp_r.word, got.word);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $display("%0t: status expected %h actual %h", $time, exp_r.status, got.status);
        errors++;
      end
      if (got.count !== exp_r.count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time, exp_r.count,
                 got.count);
        errors++;
      end
      if (got.empty_flag !== exp_r.empty_flag) begin
        $display("%0t: is_empty expected %b actual %b", $time, exp_r.empty_flag,
                 got.empty_flag);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals
  // --------------------------------------------------------------------------
  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // op[2:0], data_word[34:3], zero pad
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // result_word[31:0], status[33:32],
                                          // entry_count[38:34], is_empty[39]

  deque_scoreboard   sb;
  int unsigned       cycle_count = 0;
  int unsigned       tx_idle_pct;
  int unsigned       rx_idle_pct;
  logic              rx_hold_req;
  logic [WORD_W-1:0] key_pool[8];

  bounded_deque_with_match_removal u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles for the watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog: end a hung run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    logic        hold_seen;
    hold_left     = 0;
    hold_seen     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_response(m_axis_tdata);
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------

  // Offer one item, idling first at random; note it on transfer
  task automatic send_op(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word);
    while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({word, op});
    do begin
      @(posedge clk);
    end while (!(s_axis_tvalid && s_axis_tready));
    sb.note_request(op, word);
  endtask

  // Hold the input idle until every expected result has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // Mostly pool words so that removals find matches, sometimes any word
  function automatic logic [WORD_W-1:0] pick_word();
    if ($urandom_range(0, 99) < 70) begin
      return key_pool[$urandom_range(0, 7)];
    end
    return $urandom();
  endfunction

  // Random traffic in bursts that lean toward filling, draining or neither
  task automatic run_random(input int unsigned n);
    int unsigned       mode;
    int unsigned       push_pct;
    int unsigned       pop_pct;
    int unsigned       r;
    logic [OP_W-1:0]   op;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 25 == 0) begin
        mode = $urandom_range(0, 2);
      end
      case (mode)
        0:       begin push_pct = 70; pop_pct = 15; end
        1:       begin push_pct = 20; pop_pct = 60; end
        default: begin push_pct = 45; pop_pct = 37; end
      endcase
      r = $urandom_range(0, 99);
      if (r < push_pct) begin
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else if (r < push_pct + pop_pct) begin
        op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      end else if (r < 97) begin
        op = OP_REMOVE;
      end else begin
        op = OP_SPARE_5 + OP_W'($urandom_range(0, 2));
      end
      send_op(op, pick_word());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [WORD_W-1:0] dup_key;
    sb            = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    rx_hold_req   = 1'b0;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 8; i++) begin
      key_pool[i] = $urandom();
    end
    dup_key = 32'h1234_5678;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty cases and spare codes
    send_op(OP_POP_FRONT, '1);
    send_op(OP_POP_BACK, '0);
    send_op(OP_REMOVE, dup_key);
    send_op(OP_SPARE_5, '1);
    send_op(OP_SPARE_6, '0);
    send_op(OP_SPARE_7, '1);

    // Directed: fill from both ends, front pushes wrap the head index
    send_op(OP_PUSH_FRONT, '1);
    send_op(OP_PUSH_FRONT, dup_key);
    send_op(OP_PUSH_BACK, '0);
    for (int i = 0; i < 13; i++) begin
      if (i % 4 == 1) begin
        send_op(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, dup_key);
      end else begin
        send_op(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, 32'hA5A5_0000 | i);
      end
    end

    // Directed: full, removal of several matches, no match, pops
    send_op(OP_PUSH_BACK, 32'h5A5A_5A5A);
    send_op(OP_PUSH_FRONT, 32'h5A5A_5A5A);
    send_op(OP_REMOVE, dup_key);
    send_op(OP_REMOVE, 32'hDEAD_BEEF);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    wait_drained();

    // Random: sender idles lightly, receiver heavily, with one long hold-off
    tx_idle_pct = 27;
    rx_idle_pct = 84;
    rx_hold_req = 1'b1;
    run_random(150);
    wait_drained();

    // Random: roles swapped
    tx_idle_pct = 84;
    rx_idle_pct = 27;
    run_random(150);
    wait_drained();

    // Random: no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(150);
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
